// File: rtl/sliding_window_source_counter_unit_defines.svh
// ----------------------------------------------------------------------------
// Sliding window source counter - assertion macros
// Shared property templates for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SOURCE_COUNTER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_SOURCE_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset
`define SWSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset
`define SWSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/swsc_pkg.sv
// ----------------------------------------------------------------------------
// swsc_pkg
// Field widths, sizes and hash constants of the sliding window source counter.
// ----------------------------------------------------------------------------
package swsc_pkg;

    localparam int TIME_W  = 64;
    localparam int ID_W    = 32;
    localparam int DELTA_W = 32;
    localparam int COUNT_W = 11;

    localparam int RING_DEPTH_DEF   = 1024;
    localparam int BUCKET_COUNT_DEF = 4096;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Hash finalizer multipliers
    localparam logic [ID_W-1:0] HASH_C1 = 32'h85ebca6b;
    localparam logic [ID_W-1:0] HASH_C2 = 32'hc2b2ae35;

endpackage

// File: rtl/swsc_ram.sv
// ----------------------------------------------------------------------------
// swsc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/swsc_hash.sv
// ----------------------------------------------------------------------------
// swsc_hash
// Two-stage pipelined 32-bit hash finalizer, masked to the bucket index width.
// ----------------------------------------------------------------------------
module swsc_hash
    import swsc_pkg::*;
#(
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
    input  logic                            clk,
    input  logic [ID_W-1:0]                 key,
    output logic [$clog2(BUCKET_COUNT)-1:0] bucket
);

    localparam int BKT_W = $clog2(BUCKET_COUNT);

    logic [ID_W-1:0] s1_reg;
    logic [ID_W-1:0] s1_next;
    logic [ID_W-1:0] s2_reg;
    logic [ID_W-1:0] s2_next;
    logic [ID_W-1:0] mix1;
    logic [ID_W-1:0] mix2;
    logic [ID_W-1:0] mix3;

    // Fold and multiply, one multiplier per stage
    always_comb
    begin
        mix1    = key ^ (key >> 16);
        s1_next = mix1 * HASH_C1;
        mix2    = s1_reg ^ (s1_reg >> 13);
        s2_next = mix2 * HASH_C2;
        mix3    = s2_reg ^ (s2_reg >> 16);
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign bucket = mix3[BKT_W-1:0];

endmodule

// File: rtl/sliding_window_source_counter_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_source_counter_unit
// Per-request inter-arrival time and hashed source count over a sliding ring.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries arrival_time and source_id.
//   Output channel (out_valid / out_stall) returns time_delta, the time since
//   the previous request saturated to 2^32-1, and source_count, the count in
//   the source's hash bucket before this request is added.
//   Each request passes through the accept step, a step to read the ring
//   slot and store the new id, then read, read, write, write on the single
//   read port and single write port of the bucket count RAM. The result is
//   registered onto out_valid by the final write step; in_stall stays high,
//   so no new request is taken, until the previous one has left that step.
//   After reset the block sweeps the bucket RAM to zero, one entry a cycle,
//   over all BUCKET_COUNT entries (4096 by default) with in_stall high. The
//   ring needs no sweep: slots not yet written are taken as id zero.
//   When the receiver stalls, the result holds in the output register; the
//   next request is processed and waits in its final step until the
//   register is free.
// ----------------------------------------------------------------------------
`include "sliding_window_source_counter_unit_defines.svh"

module sliding_window_source_counter_unit
    import swsc_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [TIME_W-1:0]  arrival_time,
    input  logic [ID_W-1:0]    source_id,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DELTA_W-1:0] time_delta,
    output logic [COUNT_W-1:0] source_count
);

    localparam int RING_W = $clog2(RING_DEPTH);
    localparam int BKT_W  = $clog2(BUCKET_COUNT);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVICT = 3'd2;
    localparam logic [2:0] S_RDN   = 3'd3;
    localparam logic [2:0] S_RDO   = 3'd4;
    localparam logic [2:0] S_WRO   = 3'd5;
    localparam logic [2:0] S_WRN   = 3'd6;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [BKT_W-1:0]   clr_idx_reg;
    logic [BKT_W-1:0]   clr_idx_next;
    logic [TIME_W-1:0]  last_time_reg;
    logic [TIME_W-1:0]  last_time_next;
    logic [RING_W-1:0]  write_slot_reg;
    logic [RING_W-1:0]  write_slot_next;
    logic               ring_full_reg;
    logic               ring_full_next;
    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    id_next;
    logic [DELTA_W-1:0] delta_reg;
    logic [DELTA_W-1:0] delta_next;
    logic [BKT_W-1:0]   new_b_reg;
    logic [BKT_W-1:0]   new_b_next;
    logic [BKT_W-1:0]   old_b_reg;
    logic [BKT_W-1:0]   old_b_next;
    logic [COUNT_W-1:0] cnt_new_reg;
    logic [COUNT_W-1:0] cnt_new_next;
    logic [COUNT_W-1:0] dec_reg;
    logic [COUNT_W-1:0] dec_next;
    logic               same_reg;
    logic               same_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DELTA_W-1:0] out_delta_reg;
    logic [DELTA_W-1:0] out_delta_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_count_next;

    logic               accept;
    logic               out_free;
    logic [TIME_W-1:0]  diff;
    logic [RING_W-1:0]  slot_n;
    logic [ID_W-1:0]    ring_rdata;
    logic [ID_W-1:0]    evicted;
    logic [ID_W-1:0]    hash_key;
    logic [BKT_W-1:0]   hash_bucket;
    logic               cnt_we;
    logic [BKT_W-1:0]   cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [COUNT_W-1:0] cnt_rdata;
    logic [COUNT_W-1:0] dec_val;
    logic [COUNT_W-1:0] inc_base;
    logic [COUNT_W-1:0] inc_val;

    // Handshake and shared datapath terms
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign diff     = arrival_time - last_time_reg;
    assign slot_n   = write_slot_reg + RING_W'(1);
    assign evicted  = ring_full_reg ? ring_rdata : '0;
    assign hash_key = (state_reg == S_EVICT) ? evicted : source_id;
    assign dec_val  = (cnt_rdata == '0) ? '0 : cnt_rdata - COUNT_W'(1);
    assign inc_base = same_reg ? dec_reg : cnt_new_reg;
    assign inc_val  = (inc_base == COUNT_MAX) ? COUNT_MAX : inc_base + COUNT_W'(1);

    // Ring of recent source ids
    swsc_ram #(
        .WIDTH (ID_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == S_EVICT),
        .waddr (write_slot_reg),
        .wdata (id_reg),
        .raddr (slot_n),
        .rdata (ring_rdata)
    );

    // Shared hash pipeline: new id enters at accept, evicted id in the cycle after
    swsc_hash #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_hash (
        .clk    (clk),
        .key    (hash_key),
        .bucket (hash_bucket)
    );

    // Bucket count table
    swsc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BUCKET_COUNT)
    ) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (hash_bucket),
        .rdata (cnt_rdata)
    );

    // Select the count write: clearing sweep, evict decrement, new increment
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = clr_idx_reg;
        cnt_wdata = '0;
        case (state_reg)
            S_CLR:
            begin
                cnt_we = 1'b1;
            end
            S_WRO:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = old_b_reg;
                cnt_wdata = dec_val;
            end
            S_WRN:
            begin
                cnt_we    = out_free;
                cnt_waddr = new_b_reg;
                cnt_wdata = inc_val;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // Sequence one request through the tables
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        last_time_next  = last_time_reg;
        write_slot_next = write_slot_reg;
        ring_full_next  = ring_full_reg;
        id_next         = id_reg;
        delta_next      = delta_reg;
        new_b_next      = new_b_reg;
        old_b_next      = old_b_reg;
        cnt_new_next    = cnt_new_reg;
        dec_next        = dec_reg;
        same_next       = same_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_delta_next  = out_delta_reg;
        out_count_next  = out_count_reg;
        case (state_reg)
            S_CLR:
            begin
                clr_idx_next = clr_idx_reg + BKT_W'(1);
                if (clr_idx_reg == BKT_W'(BUCKET_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next         = source_id;
                    delta_next      = (diff[TIME_W-1:DELTA_W] != '0) ? '1 : diff[DELTA_W-1:0];
                    last_time_next  = arrival_time;
                    write_slot_next = slot_n;
                    state_next      = S_EVICT;
                end
            end
            S_EVICT:
            begin
                if (write_slot_reg == '0)
                begin
                    ring_full_next = 1'b1;
                end
                state_next = S_RDN;
            end
            S_RDN:
            begin
                new_b_next = hash_bucket;
                state_next = S_RDO;
            end
            S_RDO:
            begin
                old_b_next   = hash_bucket;
                cnt_new_next = cnt_rdata;
                state_next   = S_WRO;
            end
            S_WRO:
            begin
                dec_next   = dec_val;
                same_next  = (old_b_reg == new_b_reg);
                state_next = S_WRN;
            end
            S_WRN:
            begin
                // Hold the final write until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_delta_next = delta_reg;
                    out_count_next = cnt_new_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_idx_reg    <= '0;
            last_time_reg  <= '0;
            write_slot_reg <= '0;
            ring_full_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            last_time_reg  <= last_time_next;
            write_slot_reg <= write_slot_next;
            ring_full_reg  <= ring_full_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        delta_reg     <= delta_next;
        new_b_reg     <= new_b_next;
        old_b_reg     <= old_b_next;
        cnt_new_reg   <= cnt_new_next;
        dec_reg       <= dec_next;
        same_reg      <= same_next;
        out_delta_reg <= out_delta_next;
        out_count_reg <= out_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign time_delta   = out_delta_reg;
    assign source_count = out_count_reg;

    // Checks
    `SWSC_ASSERT_NEXT(a_accept_starts_evict, accept, state_reg == S_EVICT,
        "accept did not start eviction")
    `SWSC_ASSERT_NOW(a_rise_from_final, $rose(out_valid_reg), $past(state_reg) == S_WRN,
        "result loaded outside final step")
    `SWSC_ASSERT_NOW(a_count_bounded, out_valid_reg,
        32'(out_count_reg) <= 32'(RING_DEPTH), "bucket count exceeds ring depth")

endmodule
